### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers included by the rtl top level
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain condition that must hold whenever enable is high
`define ASSERT_WHEN(label, en, cond, msg) \
    `ASSERT_CLK(label, (en) |-> (cond), msg)

`endif

### design/phk3_pkg.sv
// ---------------------------------------------------------------------------
// phk3_pkg
// types, constants and tables for the 3d peano-hilbert key pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phk3_pkg;

    localparam int COORD_W    = 21;
    localparam int KEY_W      = 63;
    localparam int LEVELS_W   = 5;
    localparam int DATA_IN_W  = 64;
    localparam int DATA_OUT_W = 64;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 5'd21;

    // eight 3-bit octant codes, index 0 in the low bits
    typedef logic [7:0][2:0] dir_t;

    // starting direction order 0,1,3,2,6,7,5,4 (written from index 7 down)
    localparam dir_t START_DIR = {3'd4, 3'd5, 3'd7, 3'd6, 3'd2, 3'd3, 3'd1, 3'd0};

    // row picked by the position found, entry d gives where old entry d moves
    localparam logic [2:0] ROT_TABLE [0:7][0:7] = '{
        '{3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3},
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
        '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
        '{3'd4, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1, 3'd0, 3'd7}
    };

    // one request in flight through the level pipeline
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [LEVELS_W-1:0] n;
        dir_t                dir;
        logic [KEY_W-1:0]    key;
    } item_t;

endpackage

`default_nettype wire

### design/phk3_level_stage.sv
// ---------------------------------------------------------------------------
// phk3_level_stage
// one curve level: octant lookup, key append and direction reorder when active, registered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phk3_level_stage #(
    parameter int BIT_IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire phk3_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output phk3_pkg::item_t      out_item
);

    localparam logic [phk3_pkg::LEVELS_W-1:0] BIT_L = phk3_pkg::LEVELS_W'(BIT_IDX);

    logic            valid_reg;
    phk3_pkg::item_t item_reg;
    phk3_pkg::item_t item_next;
    logic [2:0]      code;
    logic [2:0]      pos;
    phk3_pkg::dir_t  dir_rot;
    logic            active;

    always_comb
    begin
        code   = {in_item.x[BIT_IDX], in_item.y[BIT_IDX], in_item.z[BIT_IDX]};
        // levels at or above the configured count are passed through untouched
        active = (BIT_L < in_item.n);
        pos    = '0;
        for (int p = 0; p < 8; p++)
        begin
            if (in_item.dir[p] == code)
            begin
                pos = 3'(p);
            end
        end
        dir_rot = in_item.dir;
        for (int d = 0; d < 8; d++)
        begin
            dir_rot[phk3_pkg::ROT_TABLE[pos][d]] = in_item.dir[d];
        end
        item_next = in_item;
        if (active)
        begin
            item_next.dir = dir_rot;
            item_next.key = {in_item.key[phk3_pkg::KEY_W-4:0], pos};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### design/peano_hilbert_key_3d.sv
// ---------------------------------------------------------------------------
// peano_hilbert_key_3d
// 3d peano-hilbert curve key from three unsigned coordinates
// ---------------------------------------------------------------------------
// usage:
//   input stream s_axis carries one coordinate triple per request, output
//   stream m_axis one key per request, in order. cfg_wr_en / cfg_wr_data
//   set the number of coordinate bits used (levels, saturated to
//   MAX_LEVELS); write it only while no request is in flight.
//   the pipeline has one register stage per level, MAX_LEVELS in all; each
//   request passes through every stage in turn, and one request can be
//   taken every cycle while the receiver does not stall.
//   reset empties the pipeline and sets levels to 21.
//   when the receiver stalls, the last stage holds its key and empty stages
//   in front of it keep filling; s_axis_tready drops only once every stage
//   ahead of the input is full, so nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module peano_hilbert_key_3d #(
    parameter int MAX_LEVELS = 21
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [phk3_pkg::LEVELS_W-1:0]       cfg_wr_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // coord_x [20:0], coord_y [41:21], coord_z [62:42], zero [63]
    input  wire logic [phk3_pkg::DATA_IN_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // curve_key [62:0], zero [63]
    output logic [phk3_pkg::DATA_OUT_W-1:0]          m_axis_tdata
);

    localparam logic [phk3_pkg::LEVELS_W-1:0] MAX_L = phk3_pkg::LEVELS_W'(MAX_LEVELS);

    logic [phk3_pkg::LEVELS_W-1:0] levels_reg;
    phk3_pkg::item_t               head_item;
    logic                          stg_valid [0:MAX_LEVELS];
    logic                          stg_ready [0:MAX_LEVELS];
    phk3_pkg::item_t               stg_item  [0:MAX_LEVELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= phk3_pkg::LEVELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            levels_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        head_item     = '0;
        head_item.x   = s_axis_tdata[phk3_pkg::COORD_W-1:0];
        head_item.y   = s_axis_tdata[2*phk3_pkg::COORD_W-1:phk3_pkg::COORD_W];
        head_item.z   = s_axis_tdata[3*phk3_pkg::COORD_W-1:2*phk3_pkg::COORD_W];
        head_item.n   = (levels_reg > MAX_L) ? MAX_L : levels_reg;
        head_item.dir = phk3_pkg::START_DIR;
    end

    assign stg_valid[0] = s_axis_tvalid;
    assign stg_item[0]  = head_item;
    assign s_axis_tready = stg_ready[0];

    // stage k handles coordinate bit MAX_LEVELS-1-k, top level first
    for (genvar k = 0; k < MAX_LEVELS; k++)
    begin : g_level
        phk3_level_stage #(
            .BIT_IDX (MAX_LEVELS - 1 - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    assign stg_ready[MAX_LEVELS] = m_axis_tready;
    assign m_axis_tvalid = stg_valid[MAX_LEVELS];
    assign m_axis_tdata  = {1'b0, stg_item[MAX_LEVELS].key};

    // a taken key frees the last stage, so the whole chain must move
    `ASSERT_WHEN(a_drain_frees_input, m_axis_tready, s_axis_tready,
        "input blocked although output is taken")
    // a finished key never has bits at or above three times its level count
    `ASSERT_WHEN(a_key_high_zero, m_axis_tvalid,
        ((stg_item[MAX_LEVELS].key >> (3 * stg_item[MAX_LEVELS].n)) == '0),
        "key has bits above three times levels")
    `ASSERT_WHEN(a_levels_saturated, m_axis_tvalid, (stg_item[MAX_LEVELS].n <= MAX_L),
        "level count beyond pipeline depth")

endmodule

`default_nettype wire

### tb/curve_key_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// curve_key_checker
// watches the coordinate and key streams and predicts every key.
// each accepted request is turned into an expected key. the levels setting
// used is the one in force when the request is taken. keys are compared in
// order as they leave the block.
// ---------------------------------------------------------------------------

module curve_key_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [phk3_pkg::LEVELS_W-1:0]    cfg_wr_data,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    // coord_x [20:0], coord_y [41:21], coord_z [62:42], zero [63]
    input  wire logic [phk3_pkg::DATA_IN_W-1:0]   s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // curve_key [62:0], zero [63]
    input  wire logic [phk3_pkg::DATA_OUT_W-1:0]  m_axis_tdata,
    output int                                    key_errors,
    output int                                    keys_pending
);

    localparam int MAX_LEVELS = 21;
    localparam logic [4:0] LEVELS_AT_RESET = 5'd21;

    // eight 3-bit octant codes, entry 0 in the low bits
    typedef logic [7:0][2:0] octant_order_t;

    localparam octant_order_t START_ORDER =
        {3'd4, 3'd5, 3'd7, 3'd6, 3'd2, 3'd3, 3'd1, 3'd0};

    // rotation rows, entry d tells where old entry d moves
    localparam octant_order_t TURN_0  = {3'd3, 3'd4, 3'd5, 3'd2, 3'd1, 3'd6, 3'd7, 3'd0};
    localparam octant_order_t TURN_12 = {3'd1, 3'd2, 3'd5, 3'd6, 3'd7, 3'd4, 3'd3, 3'd0};
    localparam octant_order_t TURN_34 = {3'd5, 3'd4, 3'd7, 3'd6, 3'd1, 3'd0, 3'd3, 3'd2};
    localparam octant_order_t TURN_56 = {3'd7, 3'd4, 3'd3, 3'd0, 3'd1, 3'd2, 3'd5, 3'd6};
    localparam octant_order_t TURN_7  = {3'd7, 3'd0, 3'd1, 3'd6, 3'd5, 3'd2, 3'd3, 3'd4};

    localparam logic [7:0][7:0][2:0] TURN =
        {TURN_7, TURN_56, TURN_56, TURN_34, TURN_34, TURN_12, TURN_12, TURN_0};

    logic [4:0]  levels_q;
    logic [62:0] expected_keys [$];

    function automatic logic [62:0] curve_key_of(
        input logic [20:0] x,
        input logic [20:0] y,
        input logic [20:0] z,
        input logic [4:0]  lvl
    );
        octant_order_t order;
        octant_order_t prev;
        logic [2:0]    code;
        logic [2:0]    pos;
        logic [62:0]   key;
        int            n;
        int            b;
        int            p;
        int            d;
        n = (int'(lvl) > MAX_LEVELS) ? MAX_LEVELS : int'(lvl);
        order = START_ORDER;
        key = '0;
        for (b = n - 1; b >= 0; b--)
        begin
            code = {x[b], y[b], z[b]};
            pos = 3'd0;
            for (p = 0; p < 8; p++)
            begin
                if (order[p] == code)
                    pos = 3'(p);
            end
            key = {key[59:0], pos};
            prev = order;
            for (d = 0; d < 8; d++)
                order[TURN[pos][d]] = prev[d];
        end
        return key;
    endfunction

    task automatic report_key_error(input string what, input logic [62:0] got,
                                    input logic [62:0] want);
        $display("%0t ns key error: %s, got %h expected %h", $realtime, what, got, want);
        key_errors++;
    endtask

    initial
    begin
        key_errors = 0;
        keys_pending = 0;
        levels_q = LEVELS_AT_RESET;
    end

    always @(posedge clk)
    begin : watch
        logic [62:0] want;
        if (!rst_n)
        begin
            levels_q <= LEVELS_AT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                levels_q <= cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_keys.push_back(curve_key_of(s_axis_tdata[20:0],
                    s_axis_tdata[41:21], s_axis_tdata[62:42], levels_q));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_keys.size() == 0)
                begin
                    report_key_error("key with no request waiting", m_axis_tdata[62:0], '0);
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (m_axis_tdata[62:0] !== want)
                        report_key_error("curve_key", m_axis_tdata[62:0], want);
                end
            end
            // seen by the stimulus one step later, so no ordering race
            keys_pending <= expected_keys.size();
        end
    end

endmodule

### tb/peano_hilbert_key_3d_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// peano_hilbert_key_3d_tb
// stimulus and verdict for the 3d peano-hilbert key block.
// directed corner triples first, then random triples under several levels
// settings (zero, one, full, saturated, random). both stream sides idle at
// random. one long output stall fills the pipeline.
// ---------------------------------------------------------------------------

module peano_hilbert_key_3d_tb;

    localparam int LONG_HOLD = 300;
    localparam logic [20:0] COORD_MAX = 21'h1FFFFF;
    localparam logic [20:0] ALT_ODD   = 21'h155555;
    localparam logic [20:0] ALT_EVEN  = 21'h0AAAAA;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int key_errors;
    int keys_pending;
    int tx_gap_max = 10;
    int rx_gap_max = 10;
    bit rx_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    peano_hilbert_key_3d u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    curve_key_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .key_errors    (key_errors),
        .keys_pending  (keys_pending)
    );

    function automatic logic [20:0] random_coord();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return COORD_MAX;
            2: return 21'($urandom_range(15, 0));
            default: return 21'($urandom());
        endcase
    endfunction

    task automatic send_triple(input logic [20:0] x, input logic [20:0] y,
                               input logic [20:0] z);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, z, y, x};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_triple(random_coord(), random_coord(), random_coord());
    endtask

    // stop offering and wait until every key is back
    task automatic drain_keys();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (keys_pending != 0);
    endtask

    task automatic set_levels(input logic [4:0] value);
        drain_keys();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stall before each key, one long hold on request
    initial
    begin : receiver
        int stall;
        forever
        begin
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = $urandom_range(rx_gap_max, 0);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners at the reset setting of full depth
        send_triple('0, '0, '0);
        send_triple(COORD_MAX, COORD_MAX, COORD_MAX);
        send_triple(COORD_MAX, '0, '0);
        send_triple('0, COORD_MAX, '0);
        send_triple('0, '0, COORD_MAX);
        send_triple(ALT_ODD, ALT_EVEN, ALT_ODD);
        send_triple(ALT_EVEN, ALT_ODD, ALT_EVEN);
        // every octant code on the top level
        for (int c = 0; c < 8; c++)
            send_triple({c[2], 20'd0}, {c[1], 20'd0}, {c[0], 20'd0});

        // no level at all: key is zero
        set_levels(5'd0);
        send_random(20);
        // only the lowest bit counts
        set_levels(5'd1);
        send_random(30);
        // beyond the maximum, saturates to full depth
        set_levels(5'd31);
        send_random(30);

        set_levels(5'd21);
        // back-to-back requests against a long output stall
        tx_gap_max = 0;
        rx_hold_req = 1'b1;
        send_random(60);
        // no idling on either side
        rx_gap_max = 0;
        send_random(40);
        tx_gap_max = 10;
        rx_gap_max = 10;
        send_random(40);

        for (int k = 0; k < 4; k++)
        begin
            set_levels(5'($urandom_range(20, 2)));
            send_random(40);
        end

        drain_keys();
        repeat (30) @(posedge clk);
        if (key_errors == 0)
            $display("peano_hilbert_key_3d: match");
        else
            $display("peano_hilbert_key_3d: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("peano_hilbert_key_3d: mismatch");
        $finish;
    end

endmodule
